[src/fwci_pkg.sv]
// Shared types, constants and helpers for the forward-chaining inference unit.
// No dependencies.
package fwci_pkg;

    localparam int NUM_SYMBOLS = 26;
    localparam int SYM_W       = 5;
    localparam int SET_W       = NUM_SYMBOLS;
    localparam int CNT_W       = 5;
    localparam int RULE_OUT_W  = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int FIRE_LIMIT  = 26;

    typedef enum logic [1:0] {
        REQ_FACT  = 2'd0,
        REQ_RULE  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_RUN   = 2'd3
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULES = 2'd1;

    localparam logic KIND_FIRE  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;        // apply a load item (fact, rule, clear)
        logic start;       // begin a run
        logic rd;          // read rule entry at scan index
        logic fire;        // apply firing, emit record, advance
        logic next;        // skip rule, advance
        logic restart;     // begin a new pass
        logic emit_final;  // emit final record
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic req_run;
        logic idx_done;
        logic fire_ok;
        logic out_free;
        logic pass_fired;
        logic goal_hit;
        logic limit_hit;
    } t_stat;

    function automatic logic [SET_W-1:0] sym_bit(input logic [SYM_W-1:0] sym);
        logic [SET_W-1:0] b;
        b = '0;
        if (32'(sym) < NUM_SYMBOLS) begin
            b[sym] = 1'b1;
        end
        return b;
    endfunction

endpackage

[src/fwci_ctrl.sv]
// Sequencer for the inference unit: input handshake, pass/scan control.
// Depends on fwci_pkg.
module fwci_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  fwci_pkg::t_stat i_stat,
    output fwci_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PASS,
        S_FINAL
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   w_accept;

    assign w_accept   = i_s_tvalid && r_in_ready;
    assign o_s_tready = r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_stat.req_run) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_READ;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (i_stat.idx_done) begin
                    n_state = S_PASS;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.fire_ok) begin
                    // hold here until the output register can take the record
                    if (i_stat.out_free) begin
                        o_cmd.fire = 1'b1;
                        n_state    = i_stat.limit_hit ? S_FINAL : S_READ;
                    end
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_PASS: begin
                if (!i_stat.pass_fired || i_stat.goal_hit) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.restart = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

`ifndef SYNTHESIS
    a_fire_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fire |-> i_stat.out_free)
        else $error("firing issued while output register busy");

    a_final_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_final |=> (r_state == S_IDLE) && r_in_ready)
        else $error("final record did not return the sequencer to idle");
`endif

endmodule

[src/fwci_dp.sv]
// Datapath: config registers, fact set, rule memory with valid bits, scan
// counters and output register. Depends on fwci_pkg.
module fwci_dp #(
    parameter int MAX_RULES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [fwci_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fwci_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [1:0]                          i_req,
    input  logic [fwci_pkg::SYM_W-1:0]          i_fact_symbol,
    input  logic [5:0]                          i_rule_slot,
    input  logic [fwci_pkg::SET_W-1:0]          i_premise_mask,
    input  logic [fwci_pkg::SYM_W-1:0]          i_conclusion_symbol,
    input  fwci_pkg::t_cmd                      i_cmd,
    output fwci_pkg::t_stat                     o_stat,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic                                o_kind,
    output logic [fwci_pkg::RULE_OUT_W-1:0]     o_fired_rule,
    output logic [fwci_pkg::SYM_W-1:0]          o_derived_symbol,
    output logic [fwci_pkg::SET_W-1:0]          o_known_set,
    output logic                                o_goal_found,
    output logic [fwci_pkg::CNT_W-1:0]          o_firing_count,
    output logic                                o_last
);

    localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int LW = (CW > 7) ? CW : 7;

    localparam int SET_W = fwci_pkg::SET_W;
    localparam int SYM_W = fwci_pkg::SYM_W;
    localparam int CNT_W = fwci_pkg::CNT_W;

    logic [SYM_W-1:0]  r_goal;
    logic [6:0]        r_rules_in_use;
    logic [SET_W-1:0]  r_facts;
    logic [CW-1:0]     r_idx;
    logic              r_pass_fired;
    logic [CNT_W-1:0]  r_fire_total;

    logic [SET_W-1:0]  mem_prem  [MAX_RULES];
    logic [SYM_W-1:0]  mem_concl [MAX_RULES];
    logic              r_valid   [MAX_RULES];
    logic [SET_W-1:0]  r_rd_prem;
    logic [SYM_W-1:0]  r_rd_concl;
    logic              r_rd_vld;

    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [fwci_pkg::RULE_OUT_W-1:0] r_out_rule;
    logic [SYM_W-1:0]              r_out_sym;
    logic [SET_W-1:0]              r_out_set;
    logic                          r_out_goal;
    logic [CNT_W-1:0]              r_out_cnt;
    logic                          r_out_last;

    logic [LW-1:0]     w_limit;
    logic [SET_W-1:0]  w_prem;
    logic [SYM_W-1:0]  w_concl;
    logic [SET_W-1:0]  w_cbit;
    logic [SET_W-1:0]  w_goal_bit;
    logic [SET_W-1:0]  w_facts_fired;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [IW-1:0]     w_rd_addr;
    logic [IW-1:0]     w_wr_addr;
    logic              w_wr_rule;
    logic              w_goal_hit;
    logic              w_out_free;

    // scan stops at the smaller of the rule count register and the table depth
    assign w_limit = (LW'(r_rules_in_use) > LW'(MAX_RULES)) ? LW'(MAX_RULES)
                                                           : LW'(r_rules_in_use);

    assign w_prem        = r_rd_vld ? r_rd_prem  : '0;
    assign w_concl       = r_rd_vld ? r_rd_concl : '0;
    assign w_cbit        = fwci_pkg::sym_bit(w_concl);
    assign w_goal_bit    = fwci_pkg::sym_bit(r_goal);
    assign w_goal_hit    = (r_facts & w_goal_bit) != '0;
    assign w_facts_fired = r_facts | w_cbit;
    assign w_cnt_inc     = r_fire_total + CNT_W'(1);
    assign w_out_free    = !r_out_valid || i_m_tready;
    assign w_rd_addr     = r_idx[IW-1:0];
    assign w_wr_addr     = IW'(i_rule_slot);
    assign w_wr_rule     = i_cmd.load && (i_req == fwci_pkg::REQ_RULE)
                           && (32'(i_rule_slot) < MAX_RULES);

    always_comb begin
        o_stat            = '0;
        o_stat.req_run    = (i_req == fwci_pkg::REQ_RUN);
        o_stat.idx_done   = LW'(r_idx) >= w_limit;
        o_stat.fire_ok    = (w_prem != '0) && (w_cbit != '0)
                            && ((w_prem & ~r_facts) == '0)
                            && ((r_facts & w_cbit) == '0);
        o_stat.out_free   = w_out_free;
        o_stat.pass_fired = r_pass_fired;
        o_stat.goal_hit   = w_goal_hit;
        o_stat.limit_hit  = 32'(w_cnt_inc) >= fwci_pkg::FIRE_LIMIT;
    end

    // config registers, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal         <= '0;
            r_rules_in_use <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fwci_pkg::CFG_GOAL:  r_goal         <= i_cfg_data[SYM_W-1:0];
                fwci_pkg::CFG_RULES: r_rules_in_use <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // rule memory: one write port for loads, one registered read for the scan
    always_ff @(posedge i_clk) begin
        if (w_wr_rule) begin
            mem_prem[w_wr_addr]  <= i_premise_mask;
            mem_concl[w_wr_addr] <= i_conclusion_symbol;
        end
        if (i_cmd.rd) begin
            r_rd_prem  <= mem_prem[w_rd_addr];
            r_rd_concl <= mem_concl[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_RULES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (w_wr_rule) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_rd_vld <= r_valid[w_rd_addr];
            end
        end
    end

    // fact set and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_facts      <= '0;
            r_idx        <= '0;
            r_pass_fired <= 1'b0;
            r_fire_total <= '0;
        end else begin
            if (i_cmd.load) begin
                case (i_req)
                    fwci_pkg::REQ_FACT:  r_facts <= r_facts | fwci_pkg::sym_bit(i_fact_symbol);
                    fwci_pkg::REQ_CLEAR: r_facts <= '0;
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_idx        <= '0;
                r_pass_fired <= 1'b0;
                r_fire_total <= '0;
            end
            if (i_cmd.restart) begin
                r_idx        <= '0;
                r_pass_fired <= 1'b0;
            end
            if (i_cmd.next) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.fire) begin
                r_facts      <= w_facts_fired;
                r_fire_total <= w_cnt_inc;
                r_pass_fired <= 1'b1;
                r_idx        <= r_idx + CW'(1);
            end
            if (i_cmd.emit_final) begin
                r_idx <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fire || i_cmd.emit_final) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fire) begin
            r_out_kind <= fwci_pkg::KIND_FIRE;
            r_out_rule <= fwci_pkg::RULE_OUT_W'(r_idx);
            r_out_sym  <= w_concl;
            r_out_set  <= w_facts_fired;
            r_out_goal <= 1'b0;
            r_out_cnt  <= w_cnt_inc;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out_kind <= fwci_pkg::KIND_FINAL;
            r_out_rule <= '0;
            r_out_sym  <= '0;
            r_out_set  <= r_facts;
            r_out_goal <= w_goal_hit;
            r_out_cnt  <= r_fire_total;
            r_out_last <= 1'b1;
        end
    end

    assign o_m_tvalid       = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_fired_rule     = r_out_rule;
    assign o_derived_symbol = r_out_sym;
    assign o_known_set      = r_out_set;
    assign o_goal_found     = r_out_goal;
    assign o_firing_count   = r_out_cnt;
    assign o_last           = r_out_last;

`ifndef SYNTHESIS
    a_fire_sets_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire |=> (r_facts & $past(w_cbit)) != '0 && r_out_valid)
        else $error("fired conclusion missing from fact set");

    a_record_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == fwci_pkg::KIND_FIRE) |-> r_out_cnt != '0)
        else $error("firing record with zero firing count");
`endif

endmodule

[src/forward_chaining_inference_unit.sv]
// Top level of the forward-chaining inference unit: ports, field packing,
// sequencer and datapath. Depends on fwci_pkg, fwci_ctrl, fwci_dp.

// Load items (assert fact, write rule, clear facts) produce no output, and the
// input stays ready after each one. A run item scans the rule table in passes:
// each rule in use is read from the rule memory through a register and then
// evaluated, and each pass ends with an end-of-table check and a pass
// decision. A pass covers the smaller of rules_in_use and MAX_RULES entries,
// the number of passes is at most firings + 1, and an evaluate that fires or
// the final record waits while the output side stalls. Output items are one
// firing record per fired rule followed by a final record with tlast set.
// The input is not ready while a run is in progress. Config writes are always
// accepted.
module forward_chaining_inference_unit #(
    parameter int MAX_RULES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // fact_symbol[4:0], rule_slot[10:5],
                                     // premise_mask[36:11], conclusion_symbol[41:37]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // fired_rule[5:0], derived_symbol[10:6],
                                     // known_set[36:11], goal_found[37],
                                     // firing_count[42:38]
    output logic [0:0]  o_m_tuser,   // kind[0]
    output logic        o_m_tlast    // last
);

    fwci_pkg::t_cmd  w_cmd;
    fwci_pkg::t_stat w_stat;

    logic                        w_kind;
    logic [5:0]                  w_fired_rule;
    logic [fwci_pkg::SYM_W-1:0]  w_derived;
    logic [fwci_pkg::SET_W-1:0]  w_known;
    logic                        w_goal_found;
    logic [fwci_pkg::CNT_W-1:0]  w_count;
    logic                        w_last;

    assign o_cfg_ready = 1'b1;

    fwci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fwci_dp #(
        .MAX_RULES (MAX_RULES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_req               (i_s_tuser),
        .i_fact_symbol       (i_s_tdata[4:0]),
        .i_rule_slot         (i_s_tdata[10:5]),
        .i_premise_mask      (i_s_tdata[36:11]),
        .i_conclusion_symbol (i_s_tdata[41:37]),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_m_tready          (i_m_tready),
        .o_m_tvalid          (o_m_tvalid),
        .o_kind              (w_kind),
        .o_fired_rule        (w_fired_rule),
        .o_derived_symbol    (w_derived),
        .o_known_set         (w_known),
        .o_goal_found        (w_goal_found),
        .o_firing_count      (w_count),
        .o_last              (w_last)
    );

    assign o_m_tdata = {5'b0, w_count, w_goal_found, w_known, w_derived, w_fired_rule};
    assign o_m_tuser = w_kind;
    assign o_m_tlast = w_last;

endmodule

[dv/tb_forward_chaining_inference_unit.sv]
// Self-checking testbench for forward_chaining_inference_unit: directed and random
// load/run traffic checked against an in-bench inference predictor.
// Depends on fwci_pkg and the RTL under src/.
module tb_forward_chaining_inference_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SYM_W       = fwci_pkg::SYM_W;
    localparam int SET_W       = fwci_pkg::SET_W;
    localparam int CNT_W       = fwci_pkg::CNT_W;
    localparam int CFG_IDX_W   = fwci_pkg::CFG_IDX_W;
    localparam int NUM_SYMBOLS = fwci_pkg::NUM_SYMBOLS;
    localparam int FIRE_LIMIT  = fwci_pkg::FIRE_LIMIT;

    localparam int RULE_SLOTS    = 64;
    localparam int IDLE_PCT      = 38;
    localparam int HOLD_LEN      = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 120;

    // indexes outside the register map, written to check they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [5:0]       rule;
        logic [SYM_W-1:0] sym;
        logic [SET_W-1:0] known;
        logic             goal;
        logic [CNT_W-1:0] count;
        logic             tl;
    } t_record;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [47:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        o_m_tlast;

    // predictor copy of the block state and registers
    logic [SET_W-1:0] fact_bits = '0;
    logic [SET_W-1:0] premise_tbl [RULE_SLOTS];
    logic [SYM_W-1:0] conclusion_tbl [RULE_SLOTS];
    logic [SYM_W-1:0] goal_reg  = '0;
    logic [6:0]       rules_reg = '0;

    t_record pending_records [$];
    int      error_count = 0;
    int      items_sent  = 0;
    bit      calm        = 1'b0;
    int      hold_asked  = 0;
    int      hold_served = 0;
    int      hold_left   = 0;

    forward_chaining_inference_unit #(
        .MAX_RULES(RULE_SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < RULE_SLOTS; i++) begin
            premise_tbl[i]    = '0;
            conclusion_tbl[i] = '0;
        end
    end

    function automatic logic [SET_W-1:0] onehot_symbol(input logic [SYM_W-1:0] s);
        return (int'(s) < NUM_SYMBOLS) ? (SET_W'(1) << s) : '0;
    endfunction

    // Passes over the rules in use until a pass fires nothing, the goal is known or the firing limit is reached.
    task automatic infer_run();
        int               scan_len;
        int               fired_total;
        bit               pass_hit;
        bit               done;
        logic [SET_W-1:0] goal_bit;
        logic [SET_W-1:0] cbit;
        logic [SET_W-1:0] p;
        t_record          rec;
        scan_len    = (int'(rules_reg) > RULE_SLOTS) ? RULE_SLOTS : int'(rules_reg);
        goal_bit    = onehot_symbol(goal_reg);
        fired_total = 0;
        done        = 1'b0;
        while (!done) begin
            pass_hit = 1'b0;
            for (int i = 0; i < scan_len && !done; i++) begin
                p    = premise_tbl[i];
                cbit = onehot_symbol(conclusion_tbl[i]);
                if (p != '0 && cbit != '0 && (p & fact_bits) == p && (fact_bits & cbit) == '0) begin
                    fact_bits   = fact_bits | cbit;
                    fired_total++;
                    pass_hit    = 1'b1;
                    rec         = '{fwci_pkg::KIND_FIRE, 6'(i), conclusion_tbl[i], fact_bits,
                                    1'b0, CNT_W'(fired_total), 1'b0};
                    pending_records.push_back(rec);
                    if (fired_total >= FIRE_LIMIT) done = 1'b1;
                end
            end
            if (!pass_hit || (fact_bits & goal_bit) != '0) done = 1'b1;
        end
        rec = '{fwci_pkg::KIND_FINAL, 6'd0, 5'd0, fact_bits,
                ((fact_bits & goal_bit) != '0), CNT_W'(fired_total), 1'b1};
        pending_records.push_back(rec);
    endtask

    task automatic send_item(input fwci_pkg::t_req req, input logic [SYM_W-1:0] fsym,
                             input logic [5:0] slot, input logic [SET_W-1:0] prem,
                             input logic [SYM_W-1:0] concl);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, concl, prem, slot, fsym};
        i_s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        case (req)
            fwci_pkg::REQ_FACT:  fact_bits = fact_bits | onehot_symbol(fsym);
            fwci_pkg::REQ_RULE: begin
                premise_tbl[slot]    = prem;
                conclusion_tbl[slot] = concl;
            end
            fwci_pkg::REQ_CLEAR: fact_bits = '0;
            default:   infer_run();
        endcase
    endtask

    // unused fields carry random bits
    task automatic send_fact(input logic [SYM_W-1:0] s);
        send_item(fwci_pkg::REQ_FACT, s, 6'($urandom), SET_W'($urandom), 5'($urandom));
    endtask

    task automatic send_rule(input logic [5:0] slot, input logic [SET_W-1:0] prem,
                             input logic [SYM_W-1:0] concl);
        send_item(fwci_pkg::REQ_RULE, 5'($urandom), slot, prem, concl);
    endtask

    task automatic send_clear();
        send_item(fwci_pkg::REQ_CLEAR, 5'($urandom), 6'($urandom), SET_W'($urandom),
                  5'($urandom));
    endtask

    task automatic send_run();
        send_item(fwci_pkg::REQ_RUN, 5'($urandom), 6'($urandom), SET_W'($urandom),
                  5'($urandom));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            fwci_pkg::CFG_GOAL:  goal_reg  = value[SYM_W-1:0];
            fwci_pkg::CFG_RULES: rules_reg = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, drain all results, then let trailing load items finish
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_basic_chain();
        cfg_write(fwci_pkg::CFG_GOAL, 7'd2);
        cfg_write(fwci_pkg::CFG_RULES, 7'd4);
        cfg_write(CFG_SPARE_A, 7'h7F);
        cfg_write(CFG_SPARE_B, 7'h7F);
        send_fact(5'd0);
        send_fact(5'd31);                      // out of range, ignored
        send_fact(5'd26);
        send_rule(6'd0, 26'h0000001, 5'd1);    // A -> B
        send_rule(6'd1, 26'h0000003, 5'd2);    // A,B -> C
        send_rule(6'd2, 26'h0000000, 5'd3);    // empty premise never fires
        send_rule(6'd3, 26'h0000001, 5'd31);   // bad conclusion never fires
        send_run();
    endtask

    task automatic test_goal_already_known();
        send_clear();
        send_fact(5'd2);
        send_run();
    endtask

    task automatic test_multi_pass_and_extremes();
        wait_idle();
        cfg_write(fwci_pkg::CFG_RULES, 7'd0);
        send_run();
        wait_idle();
        cfg_write(fwci_pkg::CFG_GOAL, 7'h7F);   // goal 31 is never found
        cfg_write(fwci_pkg::CFG_RULES, 7'h7F);  // clipped to the full table
        // chain written backwards so each link needs its own pass
        send_rule(6'd5, 26'h0000004, 5'd3);    // C -> D
        send_rule(6'd4, 26'h0000008, 5'd4);    // D -> E
        send_rule(6'd3, 26'h0000010, 5'd5);    // E -> F
        send_rule(6'd63, 26'h3FFFFFF, 5'd0);
        send_clear();
        send_fact(5'd2);
        send_run();
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        cfg_write(fwci_pkg::CFG_RULES, 7'd6);
        send_clear();
        send_fact(5'd2);
        hold_asked <= hold_asked + 1;
        send_run();
        send_fact(5'd0);
        send_fact(5'd7);
        send_fact(5'd25);
    endtask

    task automatic test_random_traffic();
        int               start_count;
        int               episode;
        int               base;
        int               scan;
        int               pick;
        logic [6:0]       rules_val;
        logic [SET_W-1:0] prem;
        logic [SYM_W-1:0] s;
        start_count = items_sent;
        episode     = 0;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            wait_idle();
            calm <= (episode >= 6 && episode < 10);
            base = $urandom_range(0, NUM_SYMBOLS - 8);
            pick = $urandom_range(99);
            if (pick < 5)       rules_val = 7'd0;
            else if (pick < 75) rules_val = 7'($urandom_range(1, 12));
            else if (pick < 90) rules_val = 7'(RULE_SLOTS);
            else                rules_val = 7'($urandom_range(13, 127));
            cfg_write(fwci_pkg::CFG_RULES, rules_val);
            if ($urandom_range(99) < 70) begin
                cfg_write(fwci_pkg::CFG_GOAL, 7'(base + $urandom_range(0, 7)));
            end else begin
                cfg_write(fwci_pkg::CFG_GOAL, 7'($urandom_range(0, 127)));
            end
            if ($urandom_range(9) == 0)
                cfg_write($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 7'($urandom));
            scan = (int'(rules_val) > RULE_SLOTS || rules_val == 0) ? RULE_SLOTS
                                                                     : int'(rules_val);
            if ($urandom_range(99) < 40) send_clear();
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(9) == 0) s = 5'($urandom_range(0, 31));
                else                        s = 5'(base + $urandom_range(0, 3));
                send_fact(s);
            end
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(9) == 0) begin
                    send_rule(6'($urandom), SET_W'($urandom), 5'($urandom));
                end else begin
                    prem = '0;
                    repeat ($urandom_range(1, 3))
                        prem = prem | (SET_W'(1) << (base + $urandom_range(0, 7)));
                    send_rule(6'($urandom_range(0, scan - 1)), prem,
                              5'(base + $urandom_range(0, 7)));
                end
            end
            if ($urandom_range(9) != 0) send_run();
            episode++;
        end
        calm <= 1'b0;
    endtask

    // output side: random stalls, plus a long hold when a test asks for one
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_LEN;
            i_m_tready  <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_record got;
        t_record want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tuser[0], o_m_tdata[5:0], o_m_tdata[10:6], o_m_tdata[36:11],
                    o_m_tdata[37], o_m_tdata[42:38], o_m_tlast};
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
                error_count++;
            end else begin
                want = pending_records.pop_front();
                check_field("kind", 32'(want.kind), 32'(got.kind));
                check_field("fired_rule", 32'(want.rule), 32'(got.rule));
                check_field("derived_symbol", 32'(want.sym), 32'(got.sym));
                check_field("known_set", 32'(want.known), 32'(got.known));
                check_field("goal_found", 32'(want.goal), 32'(got.goal));
                check_field("firing_count", 32'(want.count), 32'(got.count));
                check_field("last", 32'(want.tl), 32'(got.tl));
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_chain();
        test_goal_already_known();
        test_multi_pass_and_extremes();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d results still outstanding", $time, pending_records.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[forward_chaining_inference_unit.f]
src/fwci_pkg.sv
src/fwci_ctrl.sv
src/fwci_dp.sv
src/forward_chaining_inference_unit.sv
dv/tb_forward_chaining_inference_unit.sv
